// ===== rtl/ole_pkg.sv =====
// Shared types, codes and sizes for the ordered list engine.
package ole_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 5;
  localparam int VAL_W  = 32;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_FIND   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_INSERT = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_FIND   = 3'd5;

  typedef struct packed {
    logic [2:0]              command;
    logic [4:0]              position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] data_out;
    logic [4:0]              found_position;
    logic [CNT_W-1:0]        length;
  } res_t;

  typedef struct packed {
    logic [2:0] act;
    logic [1:0] status;
  } chk_t;

endpackage

// ===== rtl/ole_check.sv =====
// Request check: validates position and fullness and picks the action.
module ole_check (
  input  logic [2:0]                command,
  input  logic [4:0]                position,
  input  logic [ole_pkg::CNT_W-1:0] count,
  output ole_pkg::chk_t             chk
);

  logic full;
  logic pos_in_list;
  logic pos_in_gap;

  assign full        = ({1'b0, count} >= (ole_pkg::CNT_W + 1)'(ole_pkg::DEPTH));
  assign pos_in_list = (position != 5'd0) && ({1'b0, position} <= {1'b0, count});
  assign pos_in_gap  = (position != 5'd0) && ({1'b0, position} <= ({1'b0, count} + 6'd1));

  always_comb begin
    chk.act    = ole_pkg::ACT_NONE;
    chk.status = ole_pkg::ST_OK;
    unique case (command)
      ole_pkg::CMD_APPEND: begin
        if (full) chk.status = ole_pkg::ST_FULL;
        else      chk.act    = ole_pkg::ACT_APPEND;
      end
      ole_pkg::CMD_INSERT: begin
        // position is checked before fullness
        if (!pos_in_gap) chk.status = ole_pkg::ST_BADPOS;
        else if (full)   chk.status = ole_pkg::ST_FULL;
        else             chk.act    = ole_pkg::ACT_INSERT;
      end
      ole_pkg::CMD_DELETE: begin
        if (!pos_in_list) chk.status = ole_pkg::ST_BADPOS;
        else              chk.act    = ole_pkg::ACT_DELETE;
      end
      ole_pkg::CMD_READ: begin
        if (!pos_in_list) chk.status = ole_pkg::ST_BADPOS;
        else              chk.act    = ole_pkg::ACT_READ;
      end
      ole_pkg::CMD_FIND: chk.act = ole_pkg::ACT_FIND;
      default: ;
    endcase
  end

endmodule

// ===== rtl/ordered_list_engine.sv =====
// Ordered list engine: positional insert, delete, read and search over a list memory.
//
// Requests are taken when start is high and busy is low; each request yields exactly
// one result, shown for a single cycle with out_valid, and the receiver cannot stall
// it. The list lives in one single-port-write, single-read memory of DEPTH entries,
// and every shift step moves one entry per cycle through it. Append and rejected
// requests never raise busy; read waits for the registered memory read; insert
// moves each entry from the tail down to position p one place on, then writes the
// new value at p; delete takes out the entry at p and moves the later ones toward
// the head; find scans from the head to the first match or the end of the list.
// busy goes low as out_valid goes high. The memory needs no clearing after reset.
module ordered_list_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ole_pkg::req_t in_req,
  output logic          out_valid,
  output ole_pkg::res_t out_res
);

  localparam int AW = ole_pkg::ADDR_W;
  localparam int CW = ole_pkg::CNT_W;
  localparam int VW = ole_pkg::VAL_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_RDW  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;

  logic signed [VW-1:0] mem [ole_pkg::DEPTH];
  logic signed [VW-1:0] rdata_r;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic signed [VW-1:0] mem_wdata;

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [AW-1:0]        p_r, p_nxt;
  logic signed [VW-1:0] val_r, val_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pend_addr_r, pend_addr_nxt;
  logic                 first_r, first_nxt;
  logic signed [VW-1:0] data_r, data_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ole_pkg::res_t        out_r, out_nxt;

  ole_pkg::chk_t chk;
  logic [4:0]    pos_m1;

  ole_check u_check (
    .command  (in_req.command),
    .position (in_req.position),
    .count    (count_r),
    .chk      (chk)
  );

  assign pos_m1    = in_req.position - 5'd1;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    val_nxt       = val_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    first_nxt     = first_r;
    data_nxt      = data_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = '0;
    mem_raddr     = '0;
    mem_wdata     = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt  = in_req.value;
          p_nxt    = pos_m1[AW-1:0];
          pend_nxt = 1'b0;
          unique case (chk.act)
            ole_pkg::ACT_APPEND: begin
              mem_we        = 1'b1;
              mem_waddr     = count_r[AW-1:0];
              mem_wdata     = in_req.value;
              count_nxt     = count_r + CW'(1);
              out_nxt       = '{ole_pkg::ST_OK, '0, 5'd0, count_r + CW'(1)};
              out_valid_nxt = 1'b1;
            end
            ole_pkg::ACT_INSERT: begin
              k_nxt     = count_r;
              state_nxt = S_INS;
            end
            ole_pkg::ACT_DELETE: begin
              k_nxt     = CW'(pos_m1);
              first_nxt = 1'b1;
              state_nxt = S_DEL;
            end
            ole_pkg::ACT_READ: begin
              mem_re    = 1'b1;
              mem_raddr = pos_m1[AW-1:0];
              state_nxt = S_RDW;
            end
            ole_pkg::ACT_FIND: begin
              k_nxt     = '0;
              state_nxt = S_SCAN;
            end
            default: begin
              out_nxt       = '{chk.status, '0, 5'd0, count_r};
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        // move the entry read last cycle one place toward the tail
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = rdata_r;
        end
        if (k_r > CW'(p_r)) begin
          mem_re        = 1'b1;
          mem_raddr     = AW'(k_r - CW'(1));
          pend_nxt      = 1'b1;
          pend_addr_nxt = k_r[AW-1:0];
          k_nxt         = k_r - CW'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = p_r;
          mem_wdata     = val_r;
          count_nxt     = count_r + CW'(1);
          out_nxt       = '{ole_pkg::ST_OK, '0, 5'd0, count_r + CW'(1)};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_DEL: begin
        // the first entry read is the one removed; the rest move toward the head
        if (pend_r) begin
          if (first_r) begin
            data_nxt  = rdata_r;
            first_nxt = 1'b0;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_r;
            mem_wdata = rdata_r;
          end
        end
        if (k_r < count_r) begin
          mem_re        = 1'b1;
          mem_raddr     = k_r[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = k_r[AW-1:0] - AW'(1);
          k_nxt         = k_r + CW'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          count_nxt     = count_r - CW'(1);
          out_nxt       = '{ole_pkg::ST_OK, data_r, 5'd0, count_r - CW'(1)};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_RDW: begin
        out_nxt       = '{ole_pkg::ST_OK, rdata_r, 5'd0, count_r};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_SCAN: begin
        if (pend_r && (rdata_r == val_r)) begin
          out_nxt = '{ole_pkg::ST_OK, '0, 5'({1'b0, pend_addr_r} + (AW + 1)'(1)), count_r};
          out_valid_nxt = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end else if (k_r < count_r) begin
          mem_re        = 1'b1;
          mem_raddr     = k_r[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = k_r[AW-1:0];
          k_nxt         = k_r + CW'(1);
        end else begin
          out_nxt       = '{ole_pkg::ST_NOTFOUND, '0, 5'd0, count_r};
          out_valid_nxt = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    p_r         <= p_nxt;
    val_r       <= val_nxt;
    pend_addr_r <= pend_addr_nxt;
    data_r      <= data_nxt;
    out_r       <= out_nxt;
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the ordered list engine: directed rows, then weighted random requests.
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_REQS = 700;
  localparam int CALM_TAIL   = 100;
  localparam int DRAIN_WAIT  = ole_pkg::DEPTH + 8;

  typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_BLEND} mix_t;

  typedef struct {
    logic [2:0]    cmd;
    logic [4:0]    pos;
    logic [31:0]   val;
    bit            pinned;
    ole_pkg::res_t res;
  } dir_row_t;

  logic          clk     = 1'b0;
  logic          rst_n   = 1'b0;
  logic          start   = 1'b0;
  ole_pkg::req_t in_req  = '0;
  logic          busy;
  logic          out_valid;
  ole_pkg::res_t out_res;

  // A pinned row carries its own result instead of the predicted one.
  bit            pin_use = 1'b0;
  ole_pkg::res_t pin_res = '0;

  // Predicted list contents and length, advanced at every accepted request.
  logic signed [31:0] list_mem[ole_pkg::DEPTH];
  int                 list_len = 0;

  ole_pkg::res_t pending_results[$];
  dir_row_t      dir_rows[$];
  int            fails = 0;
  int            checked = 0;
  int            by_status[4] = '{0, 0, 0, 0};
  int            longest = 0;

  ordered_list_engine i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  always #2 clk = ~clk;

  task automatic apply_list_op(input ole_pkg::req_t r, output ole_pkg::res_t res);
    int p;
    p = int'(r.position);
    res = '0;
    res.status = ole_pkg::ST_OK;
    case (r.command)
      ole_pkg::CMD_APPEND: begin
        if (list_len >= ole_pkg::DEPTH) begin
          res.status = ole_pkg::ST_FULL;
        end else begin
          list_mem[list_len] = r.value;
          list_len++;
        end
      end
      ole_pkg::CMD_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          res.status = ole_pkg::ST_BADPOS;
        end else if (list_len >= ole_pkg::DEPTH) begin
          res.status = ole_pkg::ST_FULL;
        end else begin
          for (int k = list_len; k > p - 1; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = r.value;
          list_len++;
        end
      end
      ole_pkg::CMD_DELETE: begin
        if (p < 1 || p > list_len) begin
          res.status = ole_pkg::ST_BADPOS;
        end else begin
          res.data_out = list_mem[p-1];
          for (int k = p - 1; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
        end
      end
      ole_pkg::CMD_READ: begin
        if (p < 1 || p > list_len) res.status = ole_pkg::ST_BADPOS;
        else res.data_out = list_mem[p-1];
      end
      ole_pkg::CMD_FIND: begin
        res.status = ole_pkg::ST_NOTFOUND;
        for (int k = 0; k < list_len; k++) begin
          if (res.status == ole_pkg::ST_NOTFOUND && list_mem[k] == r.value) begin
            res.status = ole_pkg::ST_OK;
            res.found_position = 5'(k + 1);
          end
        end
      end
      default: ;
    endcase
    res.length = 5'(list_len);
  endtask

  // Check each strobed result against the oldest expectation, then log new requests.
  always @(posedge clk) begin : watch
    ole_pkg::res_t want;
    ole_pkg::res_t pred;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = pending_results.pop_front();
          checked++;
          by_status[want.status]++;
          if (out_res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_res.status);
            fails++;
          end
          if (out_res.data_out !== want.data_out) begin
            $error("data_out: expected %0d, got %0d", want.data_out, out_res.data_out);
            fails++;
          end
          if (out_res.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d", want.found_position,
                   out_res.found_position);
            fails++;
          end
          if (out_res.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, out_res.length);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        apply_list_op(in_req, pred);
        if (list_len > longest) longest = list_len;
        pending_results.push_back(pin_use ? pin_res : pred);
      end
    end
  end

  task automatic issue(input logic [2:0] cmd, input logic [4:0] pos, input logic [31:0] val,
                       input bit pinned, input ole_pkg::res_t pres);
    ole_pkg::req_t r;
    r.command  = cmd;
    r.position = pos;
    r.value    = val;
    @(negedge clk);
    start   <= 1'b1;
    in_req  <= r;
    pin_use <= pinned;
    pin_res <= pres;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic dir_row_t mk(logic [2:0] c, logic [4:0] p, logic [31:0] v, bit pin,
                                  logic [1:0] st, logic [31:0] d, logic [4:0] fp,
                                  logic [4:0] len);
    dir_row_t row;
    row.cmd = c;
    row.pos = p;
    row.val = v;
    row.pinned = pin;
    row.res.status = st;
    row.res.data_out = d;
    row.res.found_position = fp;
    row.res.length = len;
    return row;
  endfunction

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main
    mix_t        mode;
    int          phase_left;
    bit          idle_on;
    int          issued;
    int          roll;
    int          hi;
    logic [2:0]  cmd;
    logic [4:0]  pos;
    logic [31:0] val;

    // Empty list, bad positions and extremes, a mixed list of five, then spare codes.
    dir_rows.push_back(mk(ole_pkg::CMD_READ, 5'd1, 32'd0, 1, ole_pkg::ST_BADPOS, 0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_DELETE, 5'd1, 32'd0, 1, ole_pkg::ST_BADPOS, 0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_FIND, 5'd0, 32'd0, 1, ole_pkg::ST_NOTFOUND, 0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_INSERT, 5'd0, 32'd5, 1, ole_pkg::ST_BADPOS, 0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_INSERT, 5'd2, 32'd5, 1, ole_pkg::ST_BADPOS, 0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_APPEND, 5'd31, 32'h7fffffff, 1, ole_pkg::ST_OK,
                          0, 0, 1));
    dir_rows.push_back(mk(ole_pkg::CMD_APPEND, 5'd0, 32'h80000000, 1, ole_pkg::ST_OK,
                          0, 0, 2));
    dir_rows.push_back(mk(ole_pkg::CMD_INSERT, 5'd1, 32'hffffffff, 1, ole_pkg::ST_OK,
                          0, 0, 3));
    dir_rows.push_back(mk(ole_pkg::CMD_INSERT, 5'd4, 32'd0, 1, ole_pkg::ST_OK, 0, 0, 4));
    dir_rows.push_back(mk(ole_pkg::CMD_INSERT, 5'd3, 32'h55555555, 0, ole_pkg::ST_OK,
                          0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_READ, 5'd1, 32'd0, 1, ole_pkg::ST_OK,
                          32'hffffffff, 0, 5));
    dir_rows.push_back(mk(ole_pkg::CMD_READ, 5'd5, 32'd0, 0, ole_pkg::ST_OK, 0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_READ, 5'd6, 32'd0, 1, ole_pkg::ST_BADPOS, 0, 0, 5));
    dir_rows.push_back(mk(ole_pkg::CMD_READ, 5'd31, 32'd0, 1, ole_pkg::ST_BADPOS, 0, 0, 5));
    dir_rows.push_back(mk(ole_pkg::CMD_FIND, 5'd0, 32'h80000000, 0, ole_pkg::ST_OK,
                          0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_FIND, 5'd0, 32'h12345678, 1, ole_pkg::ST_NOTFOUND,
                          0, 0, 5));
    dir_rows.push_back(mk(ole_pkg::CMD_DELETE, 5'd0, 32'd0, 1, ole_pkg::ST_BADPOS, 0, 0, 5));
    dir_rows.push_back(mk(ole_pkg::CMD_DELETE, 5'd6, 32'd0, 1, ole_pkg::ST_BADPOS, 0, 0, 5));
    dir_rows.push_back(mk(ole_pkg::CMD_DELETE, 5'd5, 32'd0, 0, ole_pkg::ST_OK, 0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_DELETE, 5'd1, 32'd0, 0, ole_pkg::ST_OK, 0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_FIND + 3'd1, 5'd3, 32'hdeadbeef, 0, ole_pkg::ST_OK,
                          0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_FIND + 3'd2, 5'd1, 32'h0, 0, ole_pkg::ST_OK,
                          0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_FIND + 3'd3, 5'd31, 32'hffffffff, 0, ole_pkg::ST_OK,
                          0, 0, 0));
    dir_rows.push_back(mk(ole_pkg::CMD_INSERT, 5'd17, 32'd9, 1, ole_pkg::ST_BADPOS, 0, 0, 3));
    dir_rows.push_back(mk(ole_pkg::CMD_FIND, 5'd0, 32'h7fffffff, 0, ole_pkg::ST_OK,
                          0, 0, 0));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      issue(dir_rows[i].cmd, dir_rows[i].pos, dir_rows[i].val, dir_rows[i].pinned,
            dir_rows[i].res);
      if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 12));
    end

    // Random part: phases that grow, shrink or churn the list, so it fills and empties often.
    mode = MIX_GROW;
    phase_left = $urandom_range(30, 60);
    idle_on = 1'b1;
    issued = 0;
    while (issued < RANDOM_REQS) begin
      if (phase_left == 0) begin
        mode = mix_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 60);
        idle_on = (issued < RANDOM_REQS - CALM_TAIL) && ($urandom_range(0, 9) < 7);
      end
      phase_left--;

      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        cmd = ole_pkg::CMD_FIND + 3'($urandom_range(1, 3));
      end else begin
        case (mode)
          MIX_GROW: begin
            if (roll < 45) cmd = ole_pkg::CMD_APPEND;
            else if (roll < 80) cmd = ole_pkg::CMD_INSERT;
            else if (roll < 88) cmd = ole_pkg::CMD_FIND;
            else if (roll < 94) cmd = ole_pkg::CMD_READ;
            else cmd = ole_pkg::CMD_DELETE;
          end
          MIX_SHRINK: begin
            if (roll < 10) cmd = ole_pkg::CMD_APPEND;
            else if (roll < 20) cmd = ole_pkg::CMD_INSERT;
            else if (roll < 70) cmd = ole_pkg::CMD_DELETE;
            else if (roll < 85) cmd = ole_pkg::CMD_READ;
            else cmd = ole_pkg::CMD_FIND;
          end
          default: begin
            if (roll < 23) cmd = ole_pkg::CMD_APPEND;
            else if (roll < 43) cmd = ole_pkg::CMD_INSERT;
            else if (roll < 63) cmd = ole_pkg::CMD_DELETE;
            else if (roll < 80) cmd = ole_pkg::CMD_READ;
            else cmd = ole_pkg::CMD_FIND;
          end
        endcase
      end

      // Mostly legal positions; the rest land on the edges or anywhere in the field.
      hi = (cmd == ole_pkg::CMD_INSERT) ? list_len + 1 : list_len;
      if (hi >= 1 && $urandom_range(0, 99) < 85) begin
        pos = 5'($urandom_range(1, hi));
      end else begin
        case ($urandom_range(0, 3))
          0: pos = 5'd0;
          1: pos = 5'(hi + 1);
          2: pos = 5'd17;
          default: pos = 5'($urandom_range(0, 31));
        endcase
      end

      // Searches mostly hit a stored value; a small pool makes duplicates likely.
      if (cmd == ole_pkg::CMD_FIND && list_len > 0 && $urandom_range(0, 9) < 6) begin
        val = list_mem[$urandom_range(0, list_len - 1)];
      end else if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: val = 32'h0;
          1: val = 32'h1;
          2: val = 32'hffffffff;
          3: val = 32'h7fffffff;
          4: val = 32'h80000000;
          default: val = 32'h5;
        endcase
      end else begin
        val = $urandom();
      end

      issue(cmd, pos, val, 1'b0, '0);
      if (cmd <= ole_pkg::CMD_FIND) issued++;
      if (idle_on && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 12));
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("checked %0d results: %0d ok, %0d bad position, %0d list full, %0d not found",
             checked, by_status[ole_pkg::ST_OK], by_status[ole_pkg::ST_BADPOS],
             by_status[ole_pkg::ST_FULL], by_status[ole_pkg::ST_NOTFOUND]);
    $display("list reached %0d of %0d entries", longest, ole_pkg::DEPTH);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ole_pkg.sv
rtl/ole_check.sv
rtl/ordered_list_engine.sv
bench/testbench.sv
